// ===== rtl/core/qvt_pkg.sv =====
`timescale 1ns / 1ps

package qvt_pkg;

    localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
    localparam int unsigned QUEUE_DEPTH = 2;

    // saturation bounds of the accumulator
    localparam logic signed [36:0] SAT_MAX = 37'sd2147483647;
    localparam logic signed [36:0] SAT_MIN = -37'sd2147483648;

    // command codes
    typedef enum logic [1:0] {
        FUNC_SET_POS   = 2'd0,
        FUNC_TRANSLATE = 2'd1,
        FUNC_ROTATE    = 2'd2,
        FUNC_READ      = 2'd3
    } func_t;

    // operand sources of the shared multiplier
    typedef enum logic [2:0] {
        SRC_ZERO = 3'd0,
        SRC_ONE  = 3'd1,
        SRC_QUAT = 3'd2,
        SRC_EYE  = 3'd3,
        SRC_VA   = 3'd4,
        SRC_VB   = 3'd5,
        SRC_VC   = 3'd6,
        SRC_TMP  = 3'd7
    } src_t;

    // write-back targets of the accumulator
    typedef enum logic [2:0] {
        DST_NONE = 3'd0,
        DST_QUAT = 3'd1,
        DST_EYE  = 3'd2,
        DST_TMP  = 3'd3,
        DST_COL  = 3'd4
    } dst_t;

    typedef struct packed {
        func_t              func;
        logic [1:0]         axis;
        logic               obs;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
    } cmd_t;

    // one multiply-accumulate step
    typedef struct packed {
        src_t       a_src;
        logic [1:0] a_idx;
        src_t       b_src;
        logic [1:0] b_idx;
        logic       sh29;
        logic       neg;
        logic       first;
        logic       last;
        dst_t       dst;
        logic [1:0] dst_idx;
        logic       emit;
        logic       done;
    } uop_t;

    // next axis in the cycle x, y, z
    function automatic logic [1:0] axis_succ(input logic [1:0] a);
        logic [1:0] s;
        s = (a == 2'd3) ? 2'd1 : a + 2'd1;
        return s;
    endfunction

    function automatic uop_t mk(input src_t as, input logic [1:0] ai, input src_t bs,
                                input logic [1:0] bi, input logic sh29, input logic neg,
                                input logic first, input logic last, input dst_t dst,
                                input logic [1:0] di);
        uop_t u;
        u.a_src   = as;
        u.a_idx   = ai;
        u.b_src   = bs;
        u.b_idx   = bi;
        u.sh29    = sh29;
        u.neg     = neg;
        u.first   = first;
        u.last    = last;
        u.dst     = dst;
        u.dst_idx = di;
        u.emit    = 1'b0;
        u.done    = 1'b0;
        return u;
    endfunction

    // microcode: step st of a command; r is the matrix row for a read
    function automatic uop_t prog(input func_t f, input logic [1:0] ai, input logic obs,
                                  input logic [1:0] r, input logic [3:0] st);
        logic [1:0] aj;
        logic [1:0] ak;
        logic [1:0] ei;
        logic [1:0] ej;
        logic [1:0] ek;
        logic [1:0] rj;
        logic [1:0] rk;
        uop_t       u;
        aj = axis_succ(ai);
        ak = axis_succ(aj);
        ei = ai - 2'd1;
        ej = aj - 2'd1;
        ek = ak - 2'd1;
        rj = axis_succ(r);
        rk = axis_succ(rj);
        u  = mk(SRC_ZERO, 2'd0, SRC_ZERO, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_NONE, 2'd0);
        u.done = 1'b1;
        case (f)
            FUNC_SET_POS:
            begin
                case (st)
                    4'd0: u = mk(SRC_VA, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b1, 1'b1, 1'b1, DST_EYE, 2'd0);
                    4'd1: u = mk(SRC_VB, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b1, 1'b1, 1'b1, DST_EYE, 2'd1);
                    4'd2: u = mk(SRC_VC, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b1, 1'b1, 1'b1, DST_EYE, 2'd2);
                    4'd3: u = mk(SRC_ONE, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_QUAT, 2'd0);
                    4'd4: u = mk(SRC_ZERO, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_QUAT, 2'd1);
                    4'd5: u = mk(SRC_ZERO, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_QUAT, 2'd2);
                    4'd6:
                    begin
                        u = mk(SRC_ZERO, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b1, DST_QUAT, 2'd3);
                        u.done = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_TRANSLATE:
            begin
                if (obs)
                begin
                    case (st)
                        4'd0: u = mk(SRC_EYE, ei, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd1:
                        begin
                            u = mk(SRC_VA, 2'd0, SRC_ONE, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, DST_EYE, ei);
                            u.done = 1'b1;
                        end
                        default: ;
                    endcase
                end
                else
                begin
                    case (st)
                        4'd0:  u = mk(SRC_QUAT, ai, SRC_QUAT, ai, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd1:  u = mk(SRC_QUAT, 2'd0, SRC_QUAT, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
                        4'd2:  u = mk(SRC_QUAT, aj, SRC_QUAT, aj, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE, 2'd0);
                        4'd3:  u = mk(SRC_QUAT, ak, SRC_QUAT, ak, 1'b0, 1'b1, 1'b0, 1'b1, DST_TMP, 2'd0);
                        4'd4:  u = mk(SRC_QUAT, ai, SRC_QUAT, aj, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd5:  u = mk(SRC_QUAT, 2'd0, SRC_QUAT, ak, 1'b0, 1'b0, 1'b0, 1'b1, DST_TMP, 2'd1);
                        4'd6:  u = mk(SRC_QUAT, ai, SRC_QUAT, ak, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd7:  u = mk(SRC_QUAT, 2'd0, SRC_QUAT, aj, 1'b0, 1'b1, 1'b0, 1'b1, DST_TMP, 2'd2);
                        4'd8:  u = mk(SRC_EYE, ei, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd9:  u = mk(SRC_VA, 2'd0, SRC_TMP, 2'd0, 1'b0, 1'b0, 1'b0, 1'b1, DST_EYE, ei);
                        4'd10: u = mk(SRC_EYE, ej, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd11: u = mk(SRC_VA, 2'd0, SRC_TMP, 2'd1, 1'b1, 1'b0, 1'b0, 1'b1, DST_EYE, ej);
                        4'd12: u = mk(SRC_EYE, ek, SRC_ONE, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                        4'd13:
                        begin
                            u = mk(SRC_VA, 2'd0, SRC_TMP, 2'd2, 1'b1, 1'b0, 1'b0, 1'b1, DST_EYE, ek);
                            u.done = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            FUNC_ROTATE:
            begin
                case (st)
                    4'd0:  u = mk(SRC_QUAT, ai, SRC_VA, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd1:  u = mk(SRC_VB, 2'd0, SRC_QUAT, 2'd0, 1'b0, obs, 1'b0, 1'b1, DST_QUAT, ai);
                    4'd2:  u = mk(SRC_QUAT, 2'd0, SRC_VA, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd3:  u = mk(SRC_VB, 2'd0, SRC_QUAT, ai, 1'b0, !obs, 1'b0, 1'b1, DST_QUAT, 2'd0);
                    4'd4:  u = mk(SRC_QUAT, aj, SRC_VA, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd5:  u = mk(SRC_VB, 2'd0, SRC_QUAT, ak, 1'b0, 1'b0, 1'b0, 1'b1, DST_QUAT, aj);
                    4'd6:  u = mk(SRC_QUAT, ak, SRC_VA, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd7:
                    begin
                        u = mk(SRC_VB, 2'd0, SRC_QUAT, aj, 1'b0, 1'b1, 1'b0, 1'b1, DST_QUAT, ak);
                        u.done = !obs;
                    end
                    4'd8:  u = mk(SRC_VA, 2'd0, SRC_VA, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd9:  u = mk(SRC_VB, 2'd0, SRC_VB, 2'd0, 1'b0, 1'b1, 1'b0, 1'b1, DST_TMP, 2'd0);
                    4'd10: u = mk(SRC_VA, 2'd0, SRC_VB, 2'd0, 1'b1, 1'b0, 1'b1, 1'b1, DST_TMP, 2'd1);
                    4'd11: u = mk(SRC_EYE, ej, SRC_TMP, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd12: u = mk(SRC_TMP, 2'd1, SRC_EYE, ek, 1'b0, 1'b0, 1'b0, 1'b1, DST_EYE, ej);
                    4'd13: u = mk(SRC_EYE, ek, SRC_TMP, 2'd0, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd14:
                    begin
                        u = mk(SRC_TMP, 2'd1, SRC_EYE, ej, 1'b0, 1'b1, 1'b0, 1'b1, DST_EYE, ek);
                        u.done = 1'b1;
                    end
                    default: ;
                endcase
            end
            FUNC_READ:
            begin
                case (st)
                    // diagonal element
                    4'd0: u = mk(SRC_QUAT, r, SRC_QUAT, r, 1'b0, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd1: u = mk(SRC_QUAT, 2'd0, SRC_QUAT, 2'd0, 1'b0, 1'b0, 1'b0, 1'b0, DST_NONE, 2'd0);
                    4'd2: u = mk(SRC_QUAT, rj, SRC_QUAT, rj, 1'b0, 1'b1, 1'b0, 1'b0, DST_NONE, 2'd0);
                    4'd3: u = mk(SRC_QUAT, rk, SRC_QUAT, rk, 1'b0, 1'b1, 1'b0, 1'b1, DST_COL, r);
                    // column after the row axis
                    4'd4: u = mk(SRC_QUAT, r, SRC_QUAT, rj, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd5: u = mk(SRC_QUAT, rk, SRC_QUAT, 2'd0, 1'b1, 1'b0, 1'b0, 1'b1, DST_COL, rj);
                    // column before the row axis
                    4'd6: u = mk(SRC_QUAT, r, SRC_QUAT, rk, 1'b1, 1'b0, 1'b1, 1'b0, DST_NONE, 2'd0);
                    4'd7:
                    begin
                        u = mk(SRC_QUAT, rj, SRC_QUAT, 2'd0, 1'b1, 1'b1, 1'b0, 1'b1, DST_COL, rk);
                        u.emit = 1'b1;
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        return u;
    endfunction

endpackage

// ===== rtl/core/qvt_front.sv =====
`timescale 1ns / 1ps

module qvt_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [1:0]         axis,
    input  logic               observer_moves,
    input  logic signed [31:0] value_a,
    input  logic signed [31:0] value_b,
    input  logic signed [31:0] value_c,
    output logic               cmd_valid,
    input  logic               cmd_ready,
    output qvt_pkg::cmd_t      cmd
);

    qvt_pkg::cmd_t q_reg [qvt_pkg::QUEUE_DEPTH];
    logic          wr_ptr_reg;
    logic          rd_ptr_reg;
    logic [1:0]    count_reg;
    logic          accept;
    logic          keep;
    logic          push;
    logic          pop;
    qvt_pkg::cmd_t in_cmd;

    // classify: translate or rotate about axis zero has no effect
    always_comb
    begin
        in_cmd.func = qvt_pkg::func_t'(func);
        in_cmd.axis = axis;
        in_cmd.obs  = observer_moves;
        in_cmd.a    = value_a;
        in_cmd.b    = value_b;
        in_cmd.c    = value_c;
        keep = !(((in_cmd.func == qvt_pkg::FUNC_TRANSLATE) ||
                  (in_cmd.func == qvt_pkg::FUNC_ROTATE)) && (axis == 2'd0));
    end

    assign in_ready  = (count_reg != 2'(qvt_pkg::QUEUE_DEPTH));
    assign accept    = in_valid && in_ready;
    assign push      = accept && keep;
    assign cmd_valid = (count_reg != 2'd0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    // queue pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ===== rtl/core/qvt_back.sv =====
`timescale 1ns / 1ps

module qvt_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  qvt_pkg::cmd_t      cmd,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         row,
    output logic signed [31:0] elem_0,
    output logic signed [31:0] elem_1,
    output logic signed [31:0] elem_2,
    output logic signed [31:0] elem_3,
    output logic               last_row
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_ACC  = 4'b0100,
        ST_OUT  = 4'b1000
    } state_t;

    state_t             state_reg;
    qvt_pkg::cmd_t      cmd_reg;
    logic [3:0]         step_reg;
    logic [1:0]         mrow_reg;
    logic signed [31:0] quat_reg [4];
    logic signed [31:0] eye_reg [3];
    logic signed [31:0] qold_reg [4];
    logic signed [31:0] eold_reg [3];
    logic signed [31:0] tmp_reg [3];
    logic signed [63:0] prod_reg;
    qvt_pkg::uop_t      uop_reg;
    logic signed [36:0] acc_reg;
    logic               out_valid_reg;
    logic [1:0]         out_row_reg;
    logic signed [31:0] out_elem_reg [4];
    logic               out_last_reg;

    qvt_pkg::uop_t      cur_uop;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [63:0] shifted;
    logic signed [36:0] term;
    logic signed [36:0] acc_sum;
    logic signed [31:0] sat_val;
    logic               start;

    function automatic logic signed [31:0] pick(input qvt_pkg::src_t s, input logic [1:0] i,
                                                input logic signed [31:0] q [4],
                                                input logic signed [31:0] e [3],
                                                input logic signed [31:0] t [3],
                                                input qvt_pkg::cmd_t c);
        logic signed [31:0] v;
        case (s)
            qvt_pkg::SRC_ZERO: v = 32'sd0;
            qvt_pkg::SRC_ONE:  v = qvt_pkg::ONE_Q30;
            qvt_pkg::SRC_QUAT: v = q[i];
            qvt_pkg::SRC_EYE:  v = (i == 2'd3) ? 32'sd0 : e[i];
            qvt_pkg::SRC_VA:   v = c.a;
            qvt_pkg::SRC_VB:   v = c.b;
            qvt_pkg::SRC_VC:   v = c.c;
            qvt_pkg::SRC_TMP:  v = (i == 2'd3) ? 32'sd0 : t[i];
            default:           v = 32'sd0;
        endcase
        return v;
    endfunction

    // operand selection for the shared multiplier
    always_comb
    begin
        cur_uop = qvt_pkg::prog(cmd_reg.func, cmd_reg.axis, cmd_reg.obs, mrow_reg, step_reg);
        op_a    = pick(cur_uop.a_src, cur_uop.a_idx, qold_reg, eold_reg, tmp_reg, cmd_reg);
        op_b    = pick(cur_uop.b_src, cur_uop.b_idx, qold_reg, eold_reg, tmp_reg, cmd_reg);
    end

    // floor shift, sign, accumulate and saturate
    always_comb
    begin
        shifted = uop_reg.sh29 ? (prod_reg >>> 29) : (prod_reg >>> 30);
        term    = uop_reg.neg ? -shifted[36:0] : shifted[36:0];
        acc_sum = (uop_reg.first ? 37'sd0 : acc_reg) + term;
        if (acc_sum > qvt_pkg::SAT_MAX)
        begin
            sat_val = 32'sh7FFF_FFFF;
        end
        else if (acc_sum < qvt_pkg::SAT_MIN)
        begin
            sat_val = 32'sh8000_0000;
        end
        else
        begin
            sat_val = acc_sum[31:0];
        end
    end

    assign cmd_ready = (state_reg == ST_IDLE);
    assign start     = cmd_valid && cmd_ready;

    // sequencer and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= 4'd0;
            mrow_reg      <= 2'd0;
            out_valid_reg <= 1'b0;
            quat_reg[0]   <= qvt_pkg::ONE_Q30;
            quat_reg[1]   <= 32'sd0;
            quat_reg[2]   <= 32'sd0;
            quat_reg[3]   <= 32'sd0;
            eye_reg[0]    <= 32'sd0;
            eye_reg[1]    <= 32'sd0;
            eye_reg[2]    <= 32'sd0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        step_reg <= 4'd0;
                        mrow_reg <= 2'd0;
                        if (cmd.func == qvt_pkg::FUNC_READ)
                        begin
                            out_valid_reg <= 1'b1;
                            state_reg     <= ST_OUT;
                        end
                        else
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_ACC;
                end
                ST_ACC:
                begin
                    if (uop_reg.last)
                    begin
                        case (uop_reg.dst)
                            qvt_pkg::DST_QUAT: quat_reg[uop_reg.dst_idx] <= sat_val;
                            qvt_pkg::DST_EYE:
                            begin
                                if (uop_reg.dst_idx != 2'd3)
                                begin
                                    eye_reg[uop_reg.dst_idx] <= sat_val;
                                end
                            end
                            default: ;
                        endcase
                    end
                    if (uop_reg.emit)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_OUT;
                    end
                    else if (uop_reg.done)
                    begin
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        step_reg  <= step_reg + 4'd1;
                        state_reg <= ST_MUL;
                    end
                end
                ST_OUT:
                begin
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        if (mrow_reg == 2'd3)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            mrow_reg  <= mrow_reg + 2'd1;
                            step_reg  <= 4'd0;
                            state_reg <= ST_MUL;
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            cmd_reg  <= cmd;
            qold_reg <= quat_reg;
            eold_reg <= eye_reg;
            if (cmd.func == qvt_pkg::FUNC_READ)
            begin
                out_row_reg     <= 2'd0;
                out_last_reg    <= 1'b0;
                out_elem_reg[0] <= qvt_pkg::ONE_Q30;
                out_elem_reg[1] <= eye_reg[0];
                out_elem_reg[2] <= eye_reg[1];
                out_elem_reg[3] <= eye_reg[2];
            end
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= op_a * op_b;
            uop_reg  <= cur_uop;
        end
        if (state_reg == ST_ACC)
        begin
            acc_reg <= acc_sum;
            if (uop_reg.last)
            begin
                case (uop_reg.dst)
                    qvt_pkg::DST_TMP:
                    begin
                        if (uop_reg.dst_idx != 2'd3)
                        begin
                            tmp_reg[uop_reg.dst_idx] <= sat_val;
                        end
                    end
                    qvt_pkg::DST_COL: out_elem_reg[uop_reg.dst_idx] <= sat_val;
                    default: ;
                endcase
            end
            if (uop_reg.emit)
            begin
                out_row_reg     <= mrow_reg;
                out_last_reg    <= (mrow_reg == 2'd3);
                out_elem_reg[0] <= 32'sd0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign row       = out_row_reg;
    assign elem_0    = out_elem_reg[0];
    assign elem_1    = out_elem_reg[1];
    assign elem_2    = out_elem_reg[2];
    assign elem_3    = out_elem_reg[3];
    assign last_row  = out_last_reg;

endmodule

// ===== rtl/core/quaternion_view_transform.sv =====
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// input     in         in_valid/in_ready    func, axis, observer_moves, value_a..value_c
// output    out        out_valid/out_ready  row, elem_0..elem_3, last_row
//
// every multiply-accumulate step passes through a multiply and an accumulate state on one
// shared 32x32 multiplier. a matrix read shows row 0 the cycle after its start
// and computes rows 1..3 on the multiplier; every row holds until out_ready takes it.
// while it has room, a two-entry queue keeps taking commands as the engine works or a row waits.
// asynchronous reset restores the identity quaternion and a zero eye position.
module quaternion_view_transform
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         func,
    input  logic [1:0]         axis,
    input  logic               observer_moves,
    input  logic signed [31:0] value_a,
    input  logic signed [31:0] value_b,
    input  logic signed [31:0] value_c,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         row,
    output logic signed [31:0] elem_0,
    output logic signed [31:0] elem_1,
    output logic signed [31:0] elem_2,
    output logic signed [31:0] elem_3,
    output logic               last_row
);

    logic          cmd_valid;
    logic          cmd_ready;
    qvt_pkg::cmd_t cmd;

    // command intake and queue
    qvt_front u_front
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (func),
        .axis           (axis),
        .observer_moves (observer_moves),
        .value_a        (value_a),
        .value_b        (value_b),
        .value_c        (value_c),
        .cmd_valid      (cmd_valid),
        .cmd_ready      (cmd_ready),
        .cmd            (cmd)
    );

    // arithmetic engine and result register
    qvt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .row       (row),
        .elem_0    (elem_0),
        .elem_1    (elem_1),
        .elem_2    (elem_2),
        .elem_3    (elem_3),
        .last_row  (last_row)
    );

endmodule

// ===== tb/quaternion_view_transform_tb.sv =====
`timescale 1ns / 1ps

module quaternion_view_transform_tb;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] e [4];
        logic               last;
    } matrix_row_t;

    // scoreboard: own copy of the view state, expected matrix rows
    class view_scoreboard;
        int          quat [4];
        int          eye [3];
        matrix_row_t rows_due [$];
        int          mismatches;
        int          rows_seen;
        int          cmds_seen;

        function new();
            quat = '{qvt_pkg::ONE_Q30, 0, 0, 0};
            eye = '{0, 0, 0};
            mismatches = 0;
            rows_seen = 0;
            cmds_seen = 0;
        endfunction

        function longint fmul(int a, int b, int sh);
            return (longint'(a) * longint'(b)) >>> sh;
        endfunction

        function int sat(longint v);
            if (v > 64'sd2147483647)
                return 32'sh7fffffff;
            if (v < -64'sd2147483648)
                return 32'sh80000000;
            return int'(v);
        endfunction

        // an accepted command updates the state or queues four rows
        function void note_cmd(logic [1:0] f, logic [1:0] ax, logic obs,
                               int va, int vb, int vc);
            int          i;
            int          j;
            int          k;
            int          qi;
            int          qj;
            int          qk;
            int          q0;
            int          ci;
            int          cj;
            int          ck;
            int          r;
            int          fr;
            int          pj;
            int          pk;
            longint      t0;
            longint      t1;
            longint      sq [4];
            int          m [4][4];
            matrix_row_t mr;
            cmds_seen++;
            i = ax;
            j = i % 3 + 1;
            k = j % 3 + 1;
            case (f)
                qvt_pkg::FUNC_SET_POS:
                begin
                    eye[0] = sat(-longint'(va));
                    eye[1] = sat(-longint'(vb));
                    eye[2] = sat(-longint'(vc));
                    quat = '{qvt_pkg::ONE_Q30, 0, 0, 0};
                end
                qvt_pkg::FUNC_TRANSLATE:
                begin
                    if (i != 0)
                    begin
                        if (obs)
                            eye[i-1] = sat(longint'(eye[i-1]) - longint'(va));
                        else
                        begin
                            qi = quat[i]; qj = quat[j]; qk = quat[k]; q0 = quat[0];
                            ci = sat(fmul(qi, qi, 30) + fmul(q0, q0, 30)
                                     - fmul(qj, qj, 30) - fmul(qk, qk, 30));
                            cj = sat(fmul(qi, qj, 30) + fmul(q0, qk, 30));
                            ck = sat(fmul(qi, qk, 30) - fmul(q0, qj, 30));
                            eye[i-1] = sat(longint'(eye[i-1]) + fmul(va, ci, 30));
                            eye[j-1] = sat(longint'(eye[j-1]) + fmul(va, cj, 29));
                            eye[k-1] = sat(longint'(eye[k-1]) + fmul(va, ck, 29));
                        end
                    end
                end
                qvt_pkg::FUNC_ROTATE:
                begin
                    if (i != 0)
                    begin
                        qi = quat[i]; qj = quat[j]; qk = quat[k]; q0 = quat[0];
                        t0 = fmul(vb, q0, 30);
                        t1 = fmul(vb, qi, 30);
                        if (obs)
                        begin
                            t0 = -t0;
                            t1 = -t1;
                        end
                        quat[i] = sat(fmul(qi, va, 30) + t0);
                        quat[0] = sat(fmul(q0, va, 30) - t1);
                        quat[j] = sat(fmul(qj, va, 30) + fmul(vb, qk, 30));
                        quat[k] = sat(fmul(qk, va, 30) - fmul(vb, qj, 30));
                        if (obs)
                        begin
                            r = sat(fmul(va, va, 30) - fmul(vb, vb, 30));
                            fr = sat(fmul(va, vb, 29));
                            pj = eye[j-1];
                            pk = eye[k-1];
                            eye[j-1] = sat(fmul(pj, r, 30) + fmul(fr, pk, 30));
                            eye[k-1] = sat(fmul(pk, r, 30) - fmul(fr, pj, 30));
                        end
                    end
                end
                default:
                begin
                    for (int n = 0; n < 4; n++)
                        sq[n] = fmul(quat[n], quat[n], 30);
                    for (int a = 1; a < 4; a++)
                    begin
                        int b;
                        int c;
                        longint e;
                        longint g;
                        b = a % 3 + 1;
                        c = b % 3 + 1;
                        e = fmul(quat[a], quat[b], 29);
                        g = fmul(quat[c], quat[0], 29);
                        m[b][a] = sat(e - g);
                        m[a][b] = sat(e + g);
                        m[a][a] = sat(sq[a] + sq[0] - sq[b] - sq[c]);
                        m[0][a] = eye[a-1];
                        m[a][0] = 0;
                    end
                    m[0][0] = qvt_pkg::ONE_Q30;
                    for (int n = 0; n < 4; n++)
                    begin
                        mr.row = n[1:0];
                        for (int c = 0; c < 4; c++)
                            mr.e[c] = m[n][c];
                        mr.last = (n == 3);
                        rows_due.push_back(mr);
                    end
                end
            endcase
        endfunction

        // a transferred row against the oldest expected one
        function void check_row(logic [1:0] rw, logic signed [31:0] e0,
                                logic signed [31:0] e1, logic signed [31:0] e2,
                                logic signed [31:0] e3, logic lst);
            matrix_row_t x;
            rows_seen++;
            if (rows_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row transfer: row %0d", rw);
                return;
            end
            x = rows_due.pop_front();
            if (rw !== x.row || e0 !== x.e[0] || e1 !== x.e[1] || e2 !== x.e[2]
                || e3 !== x.e[3] || lst !== x.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("row mismatch exp: %0d %h %h %h %h %0d", x.row,
                             x.e[0], x.e[1], x.e[2], x.e[3], x.last);
                    $display("             got: %0d %h %h %h %h %0d", rw,
                             e0, e1, e2, e3, lst);
                end
            end
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [1:0]         func;
    logic [1:0]         axis;
    logic               observer_moves;
    logic signed [31:0] value_a;
    logic signed [31:0] value_b;
    logic signed [31:0] value_c;
    logic               out_valid;
    logic               out_ready;
    logic [1:0]         row;
    logic signed [31:0] elem_0;
    logic signed [31:0] elem_1;
    logic signed [31:0] elem_2;
    logic signed [31:0] elem_3;
    logic               last_row;

    view_scoreboard sb;
    logic           calm;
    int             cycles;

    quaternion_view_transform dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .func(func),
        .axis(axis),
        .observer_moves(observer_moves),
        .value_a(value_a),
        .value_b(value_b),
        .value_c(value_c),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .row(row),
        .elem_0(elem_0),
        .elem_1(elem_1),
        .elem_2(elem_2),
        .elem_3(elem_3),
        .last_row(last_row)
    );

    // clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver stalls
    always @(posedge clk)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
            out_ready <= calm || ($urandom_range(99) >= 25);
    end

    // row transfers
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_row(row, elem_0, elem_1, elem_2, elem_3, last_row);
    end

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 600000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // one command transfer, with random idling ahead of it
    task automatic send_cmd(logic [1:0] f, logic [1:0] ax, logic obs,
                            int va, int vb, int vc);
        if (!calm && $urandom_range(99) < 25)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        func <= f;
        axis <= ax;
        observer_moves <= obs;
        value_a <= va;
        value_b <= vb;
        value_c <= vc;
        do
            @(posedge clk);
        while (!in_ready);
        sb.note_cmd(f, ax, obs, va, vb, vc);
    endtask

    // rotation by a random angle, mostly well formed
    task automatic send_rotation(logic [1:0] ax, logic obs);
        real ang;
        ang = ($urandom_range(0, 62831) / 10000.0);
        send_cmd(qvt_pkg::FUNC_ROTATE, ax, obs, int'($cos(ang) * 1073741824.0),
                 int'($sin(ang) * 1073741824.0), $urandom);
    endtask

    function automatic int rand_pos();
        if ($urandom_range(9) == 0)
            return $urandom;
        return $signed($urandom_range(0, 32'h01ff_ffff)) - 32'sh0100_0000;
    endfunction

    initial
    begin
        int sel;
        sb = new();
        calm = 1'b0;
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        func = qvt_pkg::FUNC_SET_POS;
        axis = 2'd0;
        observer_moves = 1'b0;
        value_a = 0;
        value_b = 0;
        value_c = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset state, extremes, every command and axis
        send_cmd(qvt_pkg::FUNC_READ, 2'd0, 1'b0, 0, 0, 0);
        send_cmd(qvt_pkg::FUNC_SET_POS, 2'd0, 1'b0, 32'sh80000000, 32'sh7fffffff, 0);
        send_cmd(qvt_pkg::FUNC_READ, 2'd3, 1'b1, -1, -1, -1);
        send_cmd(qvt_pkg::FUNC_TRANSLATE, 2'd1, 1'b1, 32'sh80000000, 0, 0);
        send_cmd(qvt_pkg::FUNC_TRANSLATE, 2'd2, 1'b1, 32'sh7fffffff, 0, 0);
        send_cmd(qvt_pkg::FUNC_TRANSLATE, 2'd0, 1'b1, 32'sh1234, 0, 0);
        send_cmd(qvt_pkg::FUNC_ROTATE, 2'd0, 1'b0, 0, qvt_pkg::ONE_Q30, 0);
        send_cmd(qvt_pkg::FUNC_READ, 2'd0, 1'b0, 0, 0, 0);
        for (int a = 1; a <= 3; a++)
        begin
            send_rotation(a[1:0], 1'b0);
            send_rotation(a[1:0], 1'b1);
            send_cmd(qvt_pkg::FUNC_TRANSLATE, a[1:0], 1'b0, 32'sh0003_0000, 0, 0);
        end
        send_cmd(qvt_pkg::FUNC_READ, 2'd0, 1'b0, 0, 0, 0);
        send_cmd(qvt_pkg::FUNC_ROTATE, 2'd2, 1'b0, 32'sh7fffffff, 32'sh80000000, 0);
        send_cmd(qvt_pkg::FUNC_ROTATE, 2'd1, 1'b1, 32'sh80000000, 32'sh80000000, 0);
        send_cmd(qvt_pkg::FUNC_TRANSLATE, 2'd3, 1'b0, 32'sh80000000, 0, 0);
        send_cmd(qvt_pkg::FUNC_READ, 2'd1, 1'b0, 0, 0, 0);

        // random: mostly unit rotations and modest moves, some noise
        for (int n = 0; n < 380; n++)
        begin
            calm = (n >= 150 && n < 210);
            sel = $urandom_range(99);
            if (sel < 8)
                send_cmd(qvt_pkg::FUNC_SET_POS, 2'($urandom), 1'($urandom), rand_pos(),
                         rand_pos(), rand_pos());
            else if (sel < 35)
                send_cmd(qvt_pkg::FUNC_TRANSLATE, 2'($urandom_range(1, 3)), 1'($urandom),
                         rand_pos(), $urandom, $urandom);
            else if (sel < 60)
                send_rotation(2'($urandom_range(1, 3)), 1'($urandom));
            else if (sel < 66)
                send_cmd(2'($urandom_range(1, 2)), 2'($urandom), 1'($urandom), $urandom,
                         $urandom, $urandom);
            else
                send_cmd(qvt_pkg::FUNC_READ, 2'($urandom), 1'($urandom), $urandom,
                         $urandom, $urandom);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        // drain
        while (sb.rows_due.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);

        $display("%0d commands sent, %0d matrix rows checked, %0d mismatches",
                 sb.cmds_seen, sb.rows_seen, sb.mismatches);
        $display("covered set position, both translate and rotate modes and matrix reads");
        if (sb.mismatches == 0 && sb.rows_due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== quaternion_view_transform.f =====
rtl/core/qvt_pkg.sv
rtl/core/qvt_front.sv
rtl/core/qvt_back.sv
rtl/core/quaternion_view_transform.sv
tb/quaternion_view_transform_tb.sv
